// ===== hw/rtl/mrr_pkg.sv =====
// Shared types, constants and colour expansion helpers for the strip-to-raster unit.
// No dependencies; imported by every module of the block.
package mrr_pkg;

  localparam int LINE_WIDTH_MAX_DEF = 640;
  localparam int STRIP_ROWS_MAX_DEF = 16;

  localparam int COL_W       = 10;
  localparam int Y_W         = 12;
  localparam int COLOR_W     = 16;
  localparam int ROW_W       = 4;
  localparam int CH_W        = 8;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 10;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BLOCK_ROWS  = 4'd0,
    REG_IMAGE_WIDTH = 4'd1
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [COL_W-1:0]   pixel_x;
    logic [Y_W-1:0]     pixel_y;
    logic [COLOR_W-1:0] pixel_color;
  } pix_t;

  typedef struct packed {
    logic [COL_W-1:0] out_x;
    logic [Y_W-1:0]   out_y;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic             strip_end;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;
    logic latch;
    logic calc_row;
    logic do_write;
    logic rd_issue;
    logic drain_stop;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    op_t  item_op;
    logic tick_ok;
    logic out_busy;
  } sts_t;

  function automatic logic [CH_W-1:0] expand5(input logic [4:0] v);
    logic [14:0] t;
    t = 15'(v) * 15'd527 + 15'd23;
    return t[13:6];
  endfunction

  function automatic logic [CH_W-1:0] expand6(input logic [5:0] v);
    logic [14:0] t;
    t = 15'(v) * 15'd259 + 15'd33;
    return t[13:6];
  endfunction

endpackage

// ===== hw/rtl/mrr_ctrl.sv =====
// Sequencer for the strip-to-raster unit: clearing pass, item accept, write and drain steps.
// Depends on mrr_pkg for the command and status structs.
module mrr_ctrl
  import mrr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic pix_valid,
  output logic pix_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_WRITE,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    pix_ready  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        pix_ready = 1'b1;
        if (pix_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.item_op == OP_WRITE) begin
          cmd.calc_row = 1'b1;
          state_next   = S_WRITE;
        end else if (sts.tick_ok) begin
          cmd.rd_issue = 1'b1;
          state_next   = S_EMIT;
        end else begin
          // idle tick, or a drain position off the store: no beat
          cmd.drain_stop = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_WRITE: begin
        cmd.do_write = 1'b1;
        state_next   = S_IDLE;
      end
      S_EMIT: begin
        // read data holds until the output register frees
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/mrr_datapath.sv =====
// Datapath of the strip-to-raster unit: config registers, row split, strip store,
// drain counters and output register. Depends on mrr_pkg.
module mrr_datapath
  import mrr_pkg::*;
#(
  parameter int LINE_WIDTH_MAX = LINE_WIDTH_MAX_DEF,
  parameter int STRIP_ROWS_MAX = STRIP_ROWS_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pix_t                   pix,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   res_valid,
  input  logic                   res_ready,
  output res_t                   res,
  input  cmd_t                   cmd,
  output sts_t                   sts
);

  localparam int DEPTH  = LINE_WIDTH_MAX * STRIP_ROWS_MAX;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int H_TALL = (STRIP_ROWS_MAX < 16) ? STRIP_ROWS_MAX : 16;
  localparam int RECIP  = ((1 << 24) + H_TALL - 1) / H_TALL;

  localparam logic [12:0]       LWM13     = 13'(LINE_WIDTH_MAX);
  localparam logic [4:0]        SRM5      = 5'(STRIP_ROWS_MAX);
  localparam logic [4:0]        H_TALL5   = 5'(H_TALL);
  localparam logic [21:0]       RECIP22   = 22'(RECIP);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  // config
  logic                  block_rows_sixteen;
  logic [COL_W-1:0]      image_width;
  logic [COL_W-1:0]      eff_w;
  logic [4:0]            eff_h;

  // item and row split
  pix_t                  item;
  logic [COL_W-1:0]      quot;
  logic [33:0]           quot_prod;
  logic [14:0]           tall_prod;
  logic [Y_W-1:0]        tall_origin;
  logic [Y_W-1:0]        tall_diff;
  logic [ROW_W-1:0]      row;
  logic [Y_W-1:0]        origin;

  // drain state
  logic                  draining;
  logic [ROW_W-1:0]      drain_row;
  logic [COL_W-1:0]      drain_col;
  logic [Y_W-1:0]        strip_origin_y;
  logic                  row_end;
  logic                  last;

  // store
  logic [COLOR_W-1:0]    store [DEPTH];
  logic [COLOR_W-1:0]    rdata;
  logic [ADDR_W-1:0]     clr_addr;
  logic [ADDR_W-1:0]     mem_addr;
  logic [COLOR_W-1:0]    mem_wdata;
  logic                  mem_we;
  logic                  wr_ok;
  logic                  wr_trig;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c);
    logic [16:0] p;
    p = 17'(r) * 17'(LWM13) + 17'(c);
    return p[ADDR_W-1:0];
  endfunction

  always_comb begin
    if (image_width == '0) begin
      eff_w = COL_W'(1);
    end else if (13'(image_width) > LWM13) begin
      eff_w = LWM13[COL_W-1:0];
    end else begin
      eff_w = image_width;
    end
    eff_h = block_rows_sixteen ? H_TALL5 : 5'd8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_rows_sixteen <= 1'b1;
      image_width        <= COL_W'(640);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BLOCK_ROWS:  block_rows_sixteen <= cfg_data[0];
        REG_IMAGE_WIDTH: image_width        <= cfg_data[COL_W-1:0];
        default: ;
      endcase
    end
  end

  // y / H_TALL by reciprocal; exact for 12-bit rows, so no correction step
  assign quot_prod   = 34'(pix.pixel_y) * 34'(RECIP22);
  assign tall_prod   = 15'(quot) * 15'(H_TALL5);
  assign tall_origin = tall_prod[Y_W-1:0];
  assign tall_diff   = item.pixel_y - tall_origin;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item <= pix;
      quot <= quot_prod[33:24];
    end
    if (cmd.calc_row) begin
      if (block_rows_sixteen) begin
        row    <= tall_diff[ROW_W-1:0];
        origin <= tall_origin;
      end else begin
        row    <= {1'b0, item.pixel_y[2:0]};
        origin <= {item.pixel_y[Y_W-1:3], 3'b000};
      end
    end
  end

  assign wr_ok   = !draining && (item.pixel_x < eff_w);
  assign wr_trig = (item.pixel_x == eff_w - COL_W'(1)) && ({1'b0, row} == eff_h - 5'd1);

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = clr_addr;
    mem_wdata = '0;
    if (cmd.clear_step) begin
      mem_we = 1'b1;
    end else if (cmd.do_write) begin
      mem_addr  = addr_of(row, item.pixel_x);
      mem_wdata = item.pixel_color;
      mem_we    = wr_ok;
    end else if (cmd.rd_issue) begin
      // read-before-write: the entry is zeroed in the cycle it is read
      mem_addr = addr_of(drain_row, drain_col);
      mem_we   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_addr] <= mem_wdata;
    end
    if (cmd.rd_issue) begin
      rdata <= store[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  assign row_end = ({1'b0, drain_col} + 11'd1) >= {1'b0, eff_w};
  assign last    = row_end && (({1'b0, drain_row} + 5'd1) >= eff_h);

  always_ff @(posedge clk) begin
    if (rst) begin
      draining       <= 1'b0;
      drain_row      <= '0;
      drain_col      <= '0;
      strip_origin_y <= '0;
    end else if (cmd.do_write) begin
      if (wr_ok && wr_trig) begin
        draining       <= 1'b1;
        drain_row      <= '0;
        drain_col      <= '0;
        strip_origin_y <= origin;
      end
    end else if (cmd.drain_stop) begin
      draining <= 1'b0;
    end else if (cmd.out_load) begin
      if (last) begin
        draining  <= 1'b0;
        drain_row <= '0;
        drain_col <= '0;
      end else if (row_end) begin
        drain_col <= '0;
        drain_row <= drain_row + ROW_W'(1);
      end else begin
        drain_col <= drain_col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res.out_x     <= drain_col;
      res.out_y     <= strip_origin_y + Y_W'(drain_row);
      res.red       <= expand5(rdata[15:11]);
      res.green     <= expand6(rdata[10:5]);
      res.blue      <= expand5(rdata[4:0]);
      res.strip_end <= last;
    end
  end

  assign sts.clear_done = (clr_addr == LAST_ADDR);
  assign sts.item_op    = item.op;
  assign sts.tick_ok    = draining && (13'(drain_col) < LWM13) && (5'(drain_row) < SRM5);
  assign sts.out_busy   = res_valid && !res_ready;

endmodule

// ===== hw/rtl/mcu_strip_to_raster_rgb565_unit.sv =====
// Strip-to-raster unit, top level: joins the sequencer and the datapath.
// Depends on mrr_pkg, mrr_ctrl and mrr_datapath.
// Usage:
//   pix channel (pix_valid/pix_ready/pix): one beat per item. op = write stores a
//   block pixel into the strip store at (pixel_y mod strip height, pixel_x); the write
//   to the last column of the strip's last row starts a drain. op = tick fetches the
//   next stored pixel of the drain in raster order.
//   res channel (res_valid/res_ready/res): one beat per drain tick while draining,
//   carrying coordinates, RGB888 and strip_end on the strip's final pixel.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; index 0 sets
//   the strip height (0: 8 rows, 1: 16 rows), index 1 the image width.
// Sequencing: a write item passes accept, decode and store write; a tick is accepted,
//   decoded, read from the store and loaded to res; a tick that gives no beat ends
//   after decode. pix_ready is high only in the idle state, so no new item is taken
//   before the last is through. The write path is paced by the reciprocal multiply that
//   splits the row, the tick path by the registered read of the single-port store.
// Reset: a clearing pass zeroes the store one entry per cycle, all LINE_WIDTH_MAX x
//   STRIP_ROWS_MAX entries (10240 at defaults); pix_ready stays low meanwhile.
// Stall: the output register holds a beat while res_ready is low; a further tick
//   waits in the unit until the register frees, and no beat is lost.
module mcu_strip_to_raster_rgb565_unit
  import mrr_pkg::*;
#(
  parameter int LINE_WIDTH_MAX = LINE_WIDTH_MAX_DEF,
  parameter int STRIP_ROWS_MAX = STRIP_ROWS_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pix_valid,
  output logic                   pix_ready,
  input  pix_t                   pix,
  output logic                   res_valid,
  input  logic                   res_ready,
  output res_t                   res,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  mrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mrr_datapath #(
    .LINE_WIDTH_MAX (LINE_WIDTH_MAX),
    .STRIP_ROWS_MAX (STRIP_ROWS_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .pix       (pix),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the strip-to-raster unit: directed table, then random strips.
// Depends on mrr_pkg and mcu_strip_to_raster_rgb565_unit; checks beats against its own predictor.
`timescale 1ns / 1ps

module tb_top;
  import mrr_pkg::*;

  localparam int LINE_W      = LINE_WIDTH_MAX_DEF;
  localparam int ROWS_MAX    = STRIP_ROWS_MAX_DEF;
  localparam int ITEM_GOAL   = 1700;
  localparam int STALL_LIMIT = 40000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYC  = 12;
  localparam int DIR_ROWS    = 20;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 4'd15;

  typedef enum {ROW_PIX, ROW_CFG} row_kind_t;
  typedef enum {WANT_NONE, WANT_TYPED, WANT_MODEL} want_t;
  typedef enum {EFFECT_NONE, EFFECT_STORED, EFFECT_RESULT} effect_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    pix_t                  item;
    want_t                 want;
    res_t                  typed;
  } dir_row_t;

  // sender idles / receiver stalls, per idling phase
  int tx_pct [3] = '{37, 60, 0};
  int rx_pct [3] = '{60, 37, 0};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pix_valid = 1'b0;
  logic pix_ready;
  pix_t pix = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // predictor state
  logic [COLOR_W-1:0] strip_copy [ROWS_MAX*LINE_W];
  bit                 drain_on = 1'b0;
  int unsigned        drn_row = 0;
  int unsigned        drn_col = 0;
  logic [Y_W-1:0]     origin_y = '0;
  bit                 rows16 = 1'b1;
  logic [CFG_DATA_W-1:0] width_reg = 10'd640;

  res_t raster_due [$];
  int   mismatches = 0;
  int   effective = 0;
  int   idle_mode = 0;
  bit   hold_req = 1'b0;
  int   quiet_cycles = 0;

  mcu_strip_to_raster_rgb565_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic pix_t mk_pix(input op_t op, input int x, input int y, input int c);
    pix_t p;
    p.op          = op;
    p.pixel_x     = COL_W'(x);
    p.pixel_y     = Y_W'(y);
    p.pixel_color = COLOR_W'(c);
    return p;
  endfunction

  function automatic res_t mk_res(input int y, input int r, input int g, input int b,
                                  input bit e);
    res_t t;
    t.out_x     = '0;
    t.out_y     = Y_W'(y);
    t.red       = CH_W'(r);
    t.green     = CH_W'(g);
    t.blue      = CH_W'(b);
    t.strip_end = e;
    return t;
  endfunction

  // one accepted item: updates the strip copy, returns the raster pixel if any
  function automatic effect_t raster_predict(input pix_t it, output res_t r);
    int unsigned wuse, huse, row, idx, c5r, c6g, c5b;
    logic [COLOR_W-1:0] c;
    bit row_end, fin;
    r = '0;
    wuse = (width_reg == 0) ? 1 : ((width_reg > LINE_W) ? LINE_W : width_reg);
    huse = rows16 ? 16 : 8;
    if (huse > ROWS_MAX) huse = ROWS_MAX;
    if (it.op == OP_WRITE) begin
      if (drain_on || it.pixel_x >= wuse) return EFFECT_NONE;
      row = it.pixel_y % huse;
      strip_copy[row*LINE_W + it.pixel_x] = it.pixel_color;
      if (it.pixel_x == wuse - 1 && row == huse - 1) begin
        drain_on = 1'b1;
        drn_row  = 0;
        drn_col  = 0;
        origin_y = Y_W'(it.pixel_y - row);
      end
      return EFFECT_STORED;
    end
    if (!drain_on) return EFFECT_NONE;
    if (drn_row >= ROWS_MAX || drn_col >= LINE_W) begin
      drain_on = 1'b0;
      return EFFECT_NONE;
    end
    idx = drn_row*LINE_W + drn_col;
    c = strip_copy[idx];
    strip_copy[idx] = '0;
    c5r = c[15:11];
    c6g = c[10:5];
    c5b = c[4:0];
    row_end = (drn_col + 1 >= wuse);
    fin     = row_end && (drn_row + 1 >= huse);
    r.out_x     = COL_W'(drn_col);
    r.out_y     = Y_W'(origin_y + drn_row);
    r.red       = CH_W'((c5r*527 + 23) >> 6);
    r.green     = CH_W'((c6g*259 + 33) >> 6);
    r.blue      = CH_W'((c5b*527 + 23) >> 6);
    r.strip_end = fin;
    if (fin) begin
      drain_on = 1'b0;
      drn_row  = 0;
      drn_col  = 0;
    end else if (row_end) begin
      drn_col = 0;
      drn_row = (drn_row + 1) & 4'hF;
    end else begin
      drn_col++;
    end
    return EFFECT_RESULT;
  endfunction

  task automatic report_miss(input string what);
    mismatches++;
    if (mismatches <= 40) $display("%0t ns mismatch: %s", $time, what);
  endtask

  task automatic push_item(input pix_t it, input want_t want, input res_t typed);
    res_t    got;
    effect_t eff;
    pix       <= it;
    pix_valid <= 1'b1;
    do @(posedge clk); while (!pix_ready);
    eff = raster_predict(it, got);
    if (eff != EFFECT_NONE) effective++;
    if (want == WANT_TYPED) raster_due.push_back(typed);
    else if (want == WANT_MODEL && eff == EFFECT_RESULT) raster_due.push_back(got);
    while ($urandom_range(0, 99) < tx_pct[idle_mode]) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // drain everything outstanding, then give the unit time to finish a write
  task automatic settle();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (raster_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_BLOCK_ROWS) rows16 = val[0];
    else if (idx == REG_IMAGE_WIDTH) width_reg = CFG_DATA_W'(val);
    @(posedge clk);
  endtask

  function automatic int pick_width();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 1;
    if (r == 1) return $urandom_range(13, 48);
    return $urandom_range(2, 12);
  endfunction

  function automatic pix_t rand_pix(input op_t op, input int xlo, input int xhi);
    return mk_pix(op, $urandom_range(xlo, xhi), $urandom_range(0, 4095),
                  $urandom_range(0, 65535));
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      res_ready <= ($urandom_range(0, 99) >= rx_pct[idle_mode]);
    end
  end

  always @(posedge clk) begin : chk_res
    res_t want;
    if (!rst && res_valid && res_ready) begin
      if (raster_due.size() == 0) begin
        report_miss($sformatf("beat with nothing due x=%0d y=%0d", res.out_x, res.out_y));
      end else begin
        want = raster_due.pop_front();
        if (res.out_x != want.out_x)
          report_miss($sformatf("out_x %0d, want %0d", res.out_x, want.out_x));
        if (res.out_y != want.out_y)
          report_miss($sformatf("out_y %0d, want %0d", res.out_y, want.out_y));
        if (res.red != want.red)
          report_miss($sformatf("red %0d, want %0d", res.red, want.red));
        if (res.green != want.green)
          report_miss($sformatf("green %0d, want %0d", res.green, want.green));
        if (res.blue != want.blue)
          report_miss($sformatf("blue %0d, want %0d", res.blue, want.blue));
        if (res.strip_end != want.strip_end)
          report_miss($sformatf("strip_end %0d, want %0d", res.strip_end, want.strip_end));
      end
    end
  end

  // watchdog: no beat on any channel for too long
  always @(posedge clk) begin
    if ((pix_valid && pix_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_tab [DIR_ROWS];
    int strips, hh, w, n, cut, ticks, y;
    bit held;
    strips = 0;
    held   = 1'b0;
    foreach (strip_copy[i]) strip_copy[i] = '0;

    // 8-row strip, one column wide: every row is a row end, last row ends the strip
    dir_tab = '{
      '{ROW_PIX, REG_SPARE, '0, mk_pix(OP_TICK, 5, 9, 16'h5A5A), WANT_NONE, '0},
      '{ROW_CFG, REG_BLOCK_ROWS, 10'd0, '0, WANT_NONE, '0},
      '{ROW_CFG, REG_IMAGE_WIDTH, 10'd1, '0, WANT_NONE, '0},
      '{ROW_CFG, REG_SPARE, 10'd0, '0, WANT_NONE, '0},
      '{ROW_PIX, REG_SPARE, '0, mk_pix(OP_WRITE, 0, 4088, 16'hFFFF), WANT_NONE, '0},
      '{ROW_PIX, REG_SPARE, '0, mk_pix(OP_WRITE, 1, 4089, 16'h1234), WANT_NONE, '0},
      '{ROW_PIX, REG_SPARE, '0, mk_pix(OP_WRITE, 0, 4090, 16'hF800), WANT_NONE, '0},
      '{ROW_PIX, REG_SPARE, '0, mk_pix(OP_WRITE, 0, 4091, 16'h07E0), WANT_NONE, '0},
      '{ROW_PIX, REG_SPARE, '0, mk_pix(OP_WRITE, 0, 4092, 16'h001F), WANT_NONE, '0},
      '{ROW_PIX, REG_SPARE, '0, mk_pix(OP_WRITE, 0, 4095, 16'h0000), WANT_NONE, '0},
      '{ROW_PIX, REG_SPARE, '0, mk_pix(OP_WRITE, 0, 4093, 16'hAAAA), WANT_NONE, '0},
      '{ROW_PIX, REG_SPARE, '0, mk_pix(OP_TICK, 0, 0, 0), WANT_TYPED,
        mk_res(4088, 255, 255, 255, 1'b0)},
      '{ROW_PIX, REG_SPARE, '0, mk_pix(OP_TICK, 639, 4095, 16'hFFFF), WANT_TYPED,
        mk_res(4089, 0, 0, 0, 1'b0)},
      '{ROW_PIX, REG_SPARE, '0, mk_pix(OP_TICK, 0, 0, 0), WANT_TYPED,
        mk_res(4090, 255, 0, 0, 1'b0)},
      '{ROW_PIX, REG_SPARE, '0, mk_pix(OP_TICK, 0, 0, 0), WANT_TYPED,
        mk_res(4091, 0, 255, 0, 1'b0)},
      '{ROW_PIX, REG_SPARE, '0, mk_pix(OP_TICK, 0, 0, 0), WANT_TYPED,
        mk_res(4092, 0, 0, 255, 1'b0)},
      '{ROW_PIX, REG_SPARE, '0, mk_pix(OP_TICK, 0, 0, 0), WANT_TYPED,
        mk_res(4093, 0, 0, 0, 1'b0)},
      '{ROW_PIX, REG_SPARE, '0, mk_pix(OP_TICK, 0, 0, 0), WANT_TYPED,
        mk_res(4094, 0, 0, 0, 1'b0)},
      '{ROW_PIX, REG_SPARE, '0, mk_pix(OP_TICK, 0, 0, 0), WANT_TYPED,
        mk_res(4095, 0, 0, 0, 1'b1)},
      '{ROW_PIX, REG_SPARE, '0, mk_pix(OP_TICK, 0, 0, 0), WANT_NONE, '0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        push_item(dir_tab[i].item, dir_tab[i].want, dir_tab[i].typed);
      end
    end

    // random strips; the first is full width with a narrowing mid-drain
    while (effective < ITEM_GOAL) begin
      idle_mode = (effective < ITEM_GOAL/3) ? 0 : ((effective < 2*ITEM_GOAL/3) ? 1 : 2);
      settle();
      if (strips == 0) begin
        hh = 8;
        w  = LINE_W;
      end else begin
        hh = $urandom_range(0, 1) ? 16 : 8;
        w  = pick_width();
      end
      write_reg(REG_BLOCK_ROWS, (hh == 16));
      write_reg(REG_IMAGE_WIDTH, w);

      n = $urandom_range(0, (w*hh > 40) ? 40 : w*hh);
      repeat (n) begin
        if ($urandom_range(0, 99) < 5)
          push_item(rand_pix(OP_TICK, 0, LINE_W-1), WANT_MODEL, '0);
        else if ($urandom_range(0, 99) < 10 && w < LINE_W)
          push_item(rand_pix(OP_WRITE, w, LINE_W-1), WANT_MODEL, '0);
        else
          push_item(rand_pix(OP_WRITE, 0, w-1), WANT_MODEL, '0);
      end
      y = ($urandom_range(0, 4095) & ~(hh-1)) | (hh-1);
      push_item(mk_pix(OP_WRITE, w-1, y, $urandom_range(0, 65535)), WANT_MODEL, '0);

      if (idle_mode == 2 && !held) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      if (strips == 0) cut = w;
      else if ($urandom_range(0, 3) == 0) cut = $urandom_range(1, w*hh-1);
      else cut = -1;
      ticks = 0;
      while (drain_on) begin
        if (ticks == cut) begin
          settle();
          write_reg(REG_BLOCK_ROWS, $urandom_range(0, 1));
          write_reg(REG_IMAGE_WIDTH, (strips == 0) ? $urandom_range(1, 8) : pick_width());
        end
        if ($urandom_range(0, 99) < 8) begin
          push_item(rand_pix(OP_WRITE, 0, LINE_W-1), WANT_MODEL, '0);
        end else begin
          push_item(rand_pix(OP_TICK, 0, LINE_W-1), WANT_MODEL, '0);
          ticks++;
        end
      end
      strips++;
    end

    settle();
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
